### hdl/ppam_pkg.sv
// Package for the particle pool block: opcodes, result kinds, the slot record,
// the sequencer states and the saturating move helper.
// Depends on nothing.
package ppam_pkg;

  localparam int POOL_ENTRIES_DEF = 32;
  localparam int MAX_DRAWN = 32;
  localparam int LIVE_MAX = 63;
  localparam int PROD_W = 37;
  localparam int FRAC_SHIFT = 16;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DRAW = 2'd2;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_ADDED   = 3'd1;
  localparam logic [2:0] KIND_DROPPED = 3'd2;
  localparam logic [2:0] KIND_DRAWN   = 3'd3;
  localparam logic [2:0] KIND_NONE    = 3'd4;

  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = 24'sh800000;

  typedef struct packed {
    logic [23:0]        life;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic [23:0]        tint;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_TICK_SCAN,
    S_TICK_LIFE,
    S_TICK_MX,
    S_TICK_MY,
    S_DRAW_SCAN,
    S_DRAW_EMIT,
    S_REPLY
  } state_t;

  function automatic logic signed [23:0] move_sat(input logic signed [23:0] pos,
                                                  input logic signed [PROD_W-1:0] prod);
    logic signed [20:0] step;
    logic signed [24:0] sum;
    step = $signed(prod[PROD_W-1:FRAC_SHIFT]);
    sum  = {pos[23], pos} + {{4{step[20]}}, step};
    if (sum[24] != sum[23]) begin
      return sum[24] ? POS_MIN : POS_MAX;
    end
    return sum[23:0];
  endfunction

endpackage

### hdl/particle_pool_age_and_move.sv
// Particle pool top level: slot memory, active flags, shared multiplier and
// the sequencer that runs tick, add and draw. Depends on ppam_pkg.
//
// One transfer is taken at a time; in_ready is high only while the sequencer
// is idle. An add scans the active flags one slot per cycle until it finds a
// free slot or reaches the last one. A tick visits every slot: a free slot is
// only scanned, an active one whose life runs out is scanned and its life
// compared, and an active one that lives on goes through scan, life compare,
// then the one shared multiplier is used for x and then for y and the slot is
// written back; the result follows. A draw scans each free slot and scans and
// then emits each listed slot, waiting while the output is held. The slot memory
// has a single read and a single write port, which sets the per-slot cost.
// Drawn results are in slot order and the final one has out_last set. There is
// no clearing pass; only state, active flags, live count, out_valid are reset.
module particle_pool_age_and_move
  import ppam_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [15:0]        in_step_time,
  input  logic signed [23:0] in_start_x,
  input  logic signed [23:0] in_start_y,
  input  logic signed [19:0] in_speed_x,
  input  logic signed [19:0] in_speed_y,
  input  logic [7:0]         in_tint_red,
  input  logic [7:0]         in_tint_green,
  input  logic [7:0]         in_tint_blue,
  input  logic [23:0]        in_life_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [4:0]         out_slot,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [5:0]         out_live_count,
  output logic               out_last
);

  localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LIVE_W = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W  = $clog2(MAX_DRAWN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DRAWN - 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [POOL_ENTRIES-1:0] in_use_r, in_use_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] draw_cnt_r, draw_cnt_nxt;
  logic [2:0] reply_kind_r, reply_kind_nxt;
  logic [15:0] dt_r;
  entry_t add_r;
  entry_t work_r, work_nxt;
  entry_t rd_data_r;
  entry_t mem_wdata;
  logic mem_we;
  entry_t mem_r [POOL_ENTRIES];
  logic signed [19:0] mul_a;
  logic signed [PROD_W-1:0] prod_r;

  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;
  logic [4:0] out_slot_r, out_slot_nxt;
  logic signed [23:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [23:0] out_tint_r, out_tint_nxt;
  logic [5:0] out_live_r, out_live_nxt;
  logic out_last_r, out_last_nxt;

  logic accept, out_free, cur_used, idx_final, more_after, life_ends, draw_last;
  logic [POOL_ENTRIES-1:0] above;
  logic [5:0] live_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cur_used  = in_use_r[idx_r];
  assign idx_final = (idx_r == IDX_LAST);
  assign life_ends = (rd_data_r.life <= {8'd0, dt_r});
  assign live_sat  = (32'(live_r) > LIVE_MAX) ? 6'(LIVE_MAX) : 6'(live_r);

  always_comb begin
    for (int j = 0; j < POOL_ENTRIES; j++) begin
      above[j] = (j > int'(idx_r));
    end
  end

  assign more_after = |(in_use_r & above);
  assign draw_last  = !more_after || (draw_cnt_r == CNT_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_TICK: state_nxt = S_TICK_SCAN;
            OP_ADD:  state_nxt = S_ADD_SCAN;
            OP_DRAW: state_nxt = S_DRAW_SCAN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (!cur_used || idx_final) state_nxt = S_REPLY;
      end
      S_TICK_SCAN: begin
        if (cur_used) state_nxt = S_TICK_LIFE;
        else if (idx_final) state_nxt = S_REPLY;
      end
      S_TICK_LIFE: begin
        if (!life_ends) state_nxt = S_TICK_MX;
        else if (idx_final) state_nxt = S_REPLY;
        else state_nxt = S_TICK_SCAN;
      end
      S_TICK_MX: state_nxt = S_TICK_MY;
      S_TICK_MY: state_nxt = idx_final ? S_REPLY : S_TICK_SCAN;
      S_DRAW_SCAN: begin
        if (cur_used) state_nxt = S_DRAW_EMIT;
        else if (idx_final) state_nxt = S_REPLY;
      end
      S_DRAW_EMIT: begin
        if (out_free) state_nxt = draw_last ? S_IDLE : S_DRAW_SCAN;
      end
      S_REPLY: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    in_use_nxt     = in_use_r;
    live_nxt       = live_r;
    draw_cnt_nxt   = draw_cnt_r;
    reply_kind_nxt = reply_kind_r;
    work_nxt       = work_r;
    mem_we         = 1'b0;
    mem_wdata      = work_r;
    mul_a          = work_r.vy;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_tint_nxt   = out_tint_r;
    out_live_nxt   = out_live_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt      = '0;
          draw_cnt_nxt = '0;
        end
      end
      S_ADD_SCAN: begin
        if (!cur_used) begin
          mem_we             = 1'b1;
          mem_wdata          = add_r;
          in_use_nxt[idx_r]  = 1'b1;
          live_nxt           = live_r + 1'b1;
          reply_kind_nxt     = KIND_ADDED;
        end else if (idx_final) begin
          reply_kind_nxt = KIND_DROPPED;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK_SCAN: begin
        if (!cur_used) begin
          if (idx_final) reply_kind_nxt = KIND_TICK;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK_LIFE: begin
        mul_a = rd_data_r.vx;
        if (life_ends) begin
          in_use_nxt[idx_r] = 1'b0;
          live_nxt          = live_r - 1'b1;
          if (idx_final) reply_kind_nxt = KIND_TICK;
          else idx_nxt = idx_r + 1'b1;
        end else begin
          work_nxt      = rd_data_r;
          work_nxt.life = rd_data_r.life - {8'd0, dt_r};
        end
      end
      S_TICK_MX: begin
        work_nxt.px = move_sat(work_r.px, prod_r);
      end
      S_TICK_MY: begin
        mem_we       = 1'b1;
        mem_wdata.py = move_sat(work_r.py, prod_r);
        if (idx_final) reply_kind_nxt = KIND_TICK;
        else idx_nxt = idx_r + 1'b1;
      end
      S_DRAW_SCAN: begin
        if (!cur_used) begin
          if (idx_final) reply_kind_nxt = KIND_NONE;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAW_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DRAWN;
          out_slot_nxt  = 5'(idx_r);
          out_x_nxt     = rd_data_r.px;
          out_y_nxt     = rd_data_r.py;
          out_tint_nxt  = rd_data_r.tint;
          out_live_nxt  = live_sat;
          out_last_nxt  = draw_last;
          draw_cnt_nxt  = draw_cnt_r + 1'b1;
          if (!draw_last) idx_nxt = idx_r + 1'b1;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = reply_kind_r;
          out_slot_nxt  = (reply_kind_r == KIND_ADDED) ? 5'(idx_r) : 5'd0;
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          out_tint_nxt  = '0;
          out_live_nxt  = live_sat;
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    draw_cnt_r   <= draw_cnt_nxt;
    reply_kind_r <= reply_kind_nxt;
    work_r       <= work_nxt;
    prod_r       <= mul_a * $signed({1'b0, dt_r});
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_tint_r   <= out_tint_nxt;
    out_live_r   <= out_live_nxt;
    out_last_r   <= out_last_nxt;
    if (accept) begin
      dt_r       <= in_step_time;
      add_r.life <= in_life_time;
      add_r.px   <= in_start_x;
      add_r.py   <= in_start_y;
      add_r.vx   <= in_speed_x;
      add_r.vy   <= in_speed_y;
      add_r.tint <= {in_tint_red, in_tint_green, in_tint_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[idx_r] <= mem_wdata;
    end
    rd_data_r <= mem_r[idx_r];
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_slot       = out_slot_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_red        = out_tint_r[23:16];
  assign out_green      = out_tint_r[15:8];
  assign out_blue       = out_tint_r[7:0];
  assign out_live_count = out_live_r;
  assign out_last       = out_last_r;

  // The live counter always equals the number of active flags.
  a_live_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(live_r) == $countones(in_use_r))
    else $error("live counter out of step with active flags");

  // Aging a slot never raises the number of live slots.
  a_tick_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_LIFE) |=> (live_r <= $past(live_r)))
    else $error("tick raised the live count");

  // A report of no active particle carries a zero live count.
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NONE) |-> (out_live_count == 6'd0 && out_last))
    else $error("empty draw with live slots");

endmodule
